@@ sv/rgbc_pkg.sv @@
// shared constants, types and codes for the rgb 3x3 convolution block
package rgbc_pkg;

    localparam int MAX_WIDTH_DEF = 1024;
    localparam int MAX_HEIGHT    = 4096;
    localparam int PIX_W         = 32;
    localparam int CH_W          = 8;
    localparam int KROW_W        = 24;
    localparam int IW_W          = 11;
    localparam int IH_W          = 13;
    localparam int HW            = 13;
    localparam int CFG_W         = 24;
    localparam int CFG_IDX_W     = 3;
    localparam int ACC_W         = 20;
    localparam int KSUM_W        = 12;
    localparam int KABS_W        = 11;
    localparam int DIV_STEPS     = 8;

    localparam logic REQ_PIXEL = 1'b0;
    localparam logic REQ_FLUSH = 1'b1;

    localparam logic [CFG_IDX_W-1:0] REG_KTOP   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_KMID   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_KBOT   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 3'd4;

    localparam logic [KROW_W-1:0] KROW_RESET = 24'h010101;
    localparam logic [IW_W-1:0]   IW_RESET   = 11'd640;
    localparam logic [IH_W-1:0]   IH_RESET   = 13'd480;

    typedef struct packed {
        logic mac_first;
        logic mac;
        logic prep;
        logic step;
    } rgbc_lane_ctrl_t;

    typedef enum logic [4:0] {
        ST_IDLE = 5'b00001,
        ST_RD   = 5'b00010,
        ST_MAC  = 5'b00100,
        ST_DIV  = 5'b01000,
        ST_OUT  = 5'b10000
    } rgbc_state_t;

endpackage

@@ sv/rgbc_ram.sv @@
// generic single-port-write ram with registered read
module rgbc_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

@@ sv/rgbc_lane.sv @@
// one color lane: kernel-row multiply-accumulate and bit-serial normalizing divide
module rgbc_lane (
    input  logic                          clk,
    input  rgbc_pkg::rgbc_lane_ctrl_t     ctrl,
    input  logic [2:0][7:0]               pix,
    input  logic [2:0][7:0]               coef,
    input  logic signed [11:0]            ksum,
    output logic [7:0]                    q
);
    import rgbc_pkg::*;

    logic signed [16:0]       prod [3];
    logic signed [ACC_W-1:0]  row_sum;
    logic signed [ACC_W-1:0]  acc_reg;
    logic [ACC_W-1:0]         acc_abs;
    logic [KABS_W-1:0]        ksum_abs;
    logic [ACC_W-1:0]         rem_reg;
    logic [ACC_W-1:0]         dsh_reg;
    logic [CH_W-1:0]          quo_reg;
    logic                     zero_reg;
    logic                     sat_reg;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            prod[i] = $signed({1'b0, pix[i]}) * $signed(coef[i]);
        end
        row_sum = ACC_W'(prod[0]) + ACC_W'(prod[1]) + ACC_W'(prod[2]);
        acc_abs = acc_reg[ACC_W-1] ? ACC_W'(-acc_reg) : ACC_W'(acc_reg);
        ksum_abs = ksum[KSUM_W-1] ? KABS_W'(-ksum) : KABS_W'(ksum);
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.mac_first)
        begin
            acc_reg <= row_sum;
        end
        else if (ctrl.mac)
        begin
            acc_reg <= acc_reg + row_sum;
        end
        if (ctrl.prep)
        begin
            // opposite signs or zero numerator give a quotient at or below zero
            zero_reg <= (acc_reg == '0) || (acc_reg[ACC_W-1] != ksum[KSUM_W-1]);
            sat_reg  <= acc_abs >= ACC_W'({ksum_abs, 8'd0});
            rem_reg  <= acc_abs;
            dsh_reg  <= ACC_W'({ksum_abs, 7'd0});
            quo_reg  <= '0;
        end
        else if (ctrl.step)
        begin
            if (rem_reg >= dsh_reg)
            begin
                rem_reg <= rem_reg - dsh_reg;
                quo_reg <= {quo_reg[CH_W-2:0], 1'b1};
            end
            else
            begin
                quo_reg <= {quo_reg[CH_W-2:0], 1'b0};
            end
            dsh_reg <= dsh_reg >> 1;
        end
    end

    assign q = zero_reg ? 8'd0 : (sat_reg ? 8'd255 : quo_reg);

endmodule

@@ sv/rgb_convolution_3x3_reflect.sv @@
// top level: line buffers, 3x3 window, sequencer, three color lanes and output merge
// in_ready is high only while idle; an item that yields a result passes the 3-step
// kernel-row mac, a divide setup step, the 8-step divider and the output stage, which
// waits for room at the output, before the next item is taken; early flushes are dropped
// reset: asynchronous active low, counters cleared and registers at defaults;
// line memories are not cleared, mirroring hides their stale contents
module rgb_convolution_3x3_reflect #(
    parameter int MAX_WIDTH = rgbc_pkg::MAX_WIDTH_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_write,
    input  logic [rgbc_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [rgbc_pkg::CFG_W-1:0]      cfg_data,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic                            req_type,
    input  logic [7:0]                      in_red,
    input  logic [7:0]                      in_green,
    input  logic [7:0]                      in_blue,
    input  logic [7:0]                      in_alpha,
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic [7:0]                      out_red,
    output logic [7:0]                      out_green,
    output logic [7:0]                      out_blue,
    output logic [7:0]                      out_alpha,
    output logic                            frame_end
);
    import rgbc_pkg::*;

    localparam int AW = $clog2(MAX_WIDTH);
    localparam int CW = $clog2(MAX_WIDTH + 1);
    localparam int TW = CW + HW;
    localparam int FW_RST = (640 > MAX_WIDTH) ? MAX_WIDTH : 640;

    rgbc_state_t state_reg, state_next;

    logic [KROW_W-1:0]  krow_reg [3];
    logic [IW_W-1:0]    iw_reg;
    logic [IH_W-1:0]    ih_reg;
    logic signed [KSUM_W-1:0] ksum_reg;
    logic signed [KSUM_W-1:0] ksum_next;

    logic [CW-1:0]      fw_reg, fw_next;
    logic [HW-1:0]      fh_reg, fh_next;
    logic [TW-1:0]      tot_reg;
    logic [AW-1:0]      col_reg;
    logic [HW-1:0]      row_reg;
    logic [TW-1:0]      cnt_reg;
    logic [2:0]         step_reg;

    logic [PIX_W-1:0]   px_reg;
    logic [PIX_W-1:0]   win_reg [3][3];
    logic               lmir_reg, rmir_reg, tmir_reg, bmir_reg;
    logic               fe_reg;

    logic [PIX_W-1:0]   top_rd, mid_rd;
    logic               accept, latch, ignore;
    logic               emit;
    logic [AW:0]        col_p1;
    logic [TW-1:0]      cnt_p1;

    logic [1:0]         mrow;
    logic [PIX_W-1:0]   rpix [3];
    logic [PIX_W-1:0]   lpix, cpix, xpix;
    logic [KROW_W-1:0]  kr_sel;
    rgbc_lane_ctrl_t    lane_ctrl;
    logic [7:0]         lane_q [3];
    logic               out_valid_reg;
    logic [7:0]         out_red_reg, out_green_reg, out_blue_reg, out_alpha_reg;
    logic               frame_end_reg;
    logic               out_free;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            krow_reg[0] <= KROW_RESET;
            krow_reg[1] <= KROW_RESET;
            krow_reg[2] <= KROW_RESET;
            iw_reg      <= IW_RESET;
            ih_reg      <= IH_RESET;
            ksum_reg    <= 12'sd9;
        end
        else
        begin
            ksum_reg <= ksum_next;
            if (cfg_write)
            begin
                case (cfg_index)
                    REG_KTOP:   krow_reg[0] <= cfg_data[KROW_W-1:0];
                    REG_KMID:   krow_reg[1] <= cfg_data[KROW_W-1:0];
                    REG_KBOT:   krow_reg[2] <= cfg_data[KROW_W-1:0];
                    REG_WIDTH:  iw_reg      <= cfg_data[IW_W-1:0];
                    REG_HEIGHT: ih_reg      <= cfg_data[IH_W-1:0];
                    default:    ;
                endcase
            end
        end
    end

    always_comb
    begin
        ksum_next = '0;
        for (int r = 0; r < 3; r++)
        begin
            for (int k = 0; k < 3; k++)
            begin
                ksum_next = ksum_next + KSUM_W'($signed(krow_reg[r][8*k +: 8]));
            end
        end
        if (ksum_next == '0)
        begin
            ksum_next = 12'sd1;
        end
    end

    // frame size clamp
    always_comb
    begin
        if (iw_reg < 11'd2)
            fw_next = CW'(2);
        else if (32'(iw_reg) > MAX_WIDTH)
            fw_next = CW'(MAX_WIDTH);
        else
            fw_next = CW'(iw_reg);
        if (ih_reg < 13'd2)
            fh_next = HW'(2);
        else if (32'(ih_reg) > MAX_HEIGHT)
            fh_next = HW'(MAX_HEIGHT);
        else
            fh_next = HW'(ih_reg);
    end

    assign in_ready = (state_reg == ST_IDLE);
    assign accept   = in_valid && in_ready;
    assign latch    = accept && (req_type == REQ_PIXEL) && (row_reg == '0)
                      && (col_reg == '0) && (cnt_reg == '0);
    assign ignore   = (req_type == REQ_FLUSH) && (row_reg < fh_reg);

    // line memories: top line and middle line
    rgbc_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH)) u_top_ram (
        .clk   (clk),
        .we    (state_reg == ST_RD),
        .waddr (col_reg),
        .wdata (mid_rd),
        .re    (accept),
        .raddr (col_reg),
        .rdata (top_rd)
    );

    rgbc_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH)) u_mid_ram (
        .clk   (clk),
        .we    (state_reg == ST_RD),
        .waddr (col_reg),
        .wdata (px_reg),
        .re    (accept),
        .raddr (col_reg),
        .rdata (mid_rd)
    );

    assign emit   = ((row_reg >= HW'(2)) || ((row_reg == HW'(1)) && (col_reg != '0)))
                    && (cnt_reg < tot_reg);
    assign col_p1 = (AW + 1)'(col_reg) + 1'b1;
    assign cnt_p1 = cnt_reg + 1'b1;
    assign out_free = !out_valid_reg || out_ready;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: if (accept && !ignore) state_next = ST_RD;
            ST_RD:   state_next = emit ? ST_MAC : ST_IDLE;
            ST_MAC:  if (step_reg == 3'd3) state_next = ST_DIV;
            ST_DIV:  if (step_reg == 3'(DIV_STEPS - 1)) state_next = ST_OUT;
            ST_OUT:  if (out_free) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    // sequencer and frame counters
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            fw_reg    <= CW'(FW_RST);
            fh_reg    <= HW'(480);
            tot_reg   <= TW'(FW_RST * 480);
            col_reg   <= '0;
            row_reg   <= '0;
            cnt_reg   <= '0;
            step_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (latch)
            begin
                fw_reg  <= fw_next;
                fh_reg  <= fh_next;
                tot_reg <= TW'(fw_next * fh_next);
            end
            case (state_reg)
                ST_RD:
                begin
                    // mac steps 0..2 cover the kernel rows, step 3 sets up the divide
                    step_reg <= '0;
                    if (emit && (cnt_p1 >= tot_reg))
                    begin
                        cnt_reg <= '0;
                        col_reg <= '0;
                        row_reg <= '0;
                    end
                    else
                    begin
                        if (emit)
                            cnt_reg <= cnt_p1;
                        if (32'(col_p1) >= 32'(fw_reg))
                        begin
                            col_reg <= '0;
                            row_reg <= row_reg + 1'b1;
                        end
                        else
                        begin
                            col_reg <= col_p1[AW-1:0];
                        end
                    end
                end
                ST_MAC:  step_reg <= (step_reg == 3'd3) ? 3'd0 : step_reg + 1'b1;
                ST_DIV:  step_reg <= step_reg + 1'b1;
                default: step_reg <= '0;
            endcase
        end
    end

    // pixel capture, window shift and mirror selection
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            px_reg <= {in_alpha, in_blue, in_green, in_red};
        end
        if (state_reg == ST_RD)
        begin
            win_reg[0] <= win_reg[1];
            win_reg[1] <= win_reg[2];
            win_reg[2][0] <= top_rd;
            win_reg[2][1] <= mid_rd;
            win_reg[2][2] <= px_reg;
            fe_reg <= (cnt_p1 == tot_reg);
            if (col_reg == '0)
            begin
                // result belongs to the last column two rows above the current input
                lmir_reg <= 1'b0;
                rmir_reg <= 1'b1;
                tmir_reg <= (row_reg == HW'(2));
                bmir_reg <= ({1'b0, row_reg} == ({1'b0, fh_reg} + 1'b1));
            end
            else
            begin
                lmir_reg <= (col_reg == AW'(1));
                rmir_reg <= 1'b0;
                tmir_reg <= (row_reg == HW'(1));
                bmir_reg <= (row_reg == fh_reg);
            end
        end
    end

    // kernel row k pairs with window row 2-k and the flipped coefficient row
    always_comb
    begin
        case (step_reg)
            3'd1:    begin mrow = tmir_reg ? 2'd2 : 2'd0; kr_sel = krow_reg[2]; end
            3'd2:    begin mrow = 2'd1;                   kr_sel = krow_reg[1]; end
            default: begin mrow = bmir_reg ? 2'd0 : 2'd2; kr_sel = krow_reg[0]; end
        endcase
        for (int c = 0; c < 3; c++)
        begin
            if (mrow == 2'd0)
                rpix[c] = win_reg[c][0];
            else if (mrow == 2'd1)
                rpix[c] = win_reg[c][1];
            else
                rpix[c] = win_reg[c][2];
        end
        lpix = lmir_reg ? rpix[2] : rpix[0];
        cpix = rpix[1];
        xpix = rmir_reg ? rpix[0] : rpix[2];
    end

    always_comb
    begin
        lane_ctrl.mac_first = (state_reg == ST_MAC) && (step_reg == 3'd0);
        lane_ctrl.mac       = (state_reg == ST_MAC) && (step_reg != 3'd3);
        lane_ctrl.prep      = (state_reg == ST_MAC) && (step_reg == 3'd3);
        lane_ctrl.step      = (state_reg == ST_DIV);
    end

    for (genvar g = 0; g < 3; g++)
    begin : g_lane
        rgbc_lane u_lane (
            .clk   (clk),
            .ctrl  (lane_ctrl),
            .pix   ({xpix[8*g +: 8], cpix[8*g +: 8], lpix[8*g +: 8]}),
            .coef  ({kr_sel[7:0], kr_sel[15:8], kr_sel[23:16]}),
            .ksum  (ksum_reg),
            .q     (lane_q[g])
        );
    end

    // output merge register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if ((state_reg == ST_OUT) && out_free)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if ((state_reg == ST_OUT) && out_free)
        begin
            out_red_reg   <= lane_q[0];
            out_green_reg <= lane_q[1];
            out_blue_reg  <= lane_q[2];
            out_alpha_reg <= win_reg[1][1][31:24];
            frame_end_reg <= fe_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_red   = out_red_reg;
    assign out_green = out_green_reg;
    assign out_blue  = out_blue_reg;
    assign out_alpha = out_alpha_reg;
    assign frame_end = frame_end_reg;

    a_flush_ignored: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && ignore) |=> (state_reg == ST_IDLE))
        else $error("early flush started processing");

    a_col_in_frame: assert property (@(posedge clk) disable iff (!rst_n)
        32'(col_reg) < 32'(fw_reg))
        else $error("column counter beyond frame width");

    a_count_in_frame: assert property (@(posedge clk) disable iff (!rst_n)
        (cnt_reg < tot_reg) || (cnt_reg == '0))
        else $error("output count beyond frame size");

    a_out_loaded: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == ST_OUT) && out_free) |=> out_valid_reg)
        else $error("finished result not presented");

endmodule

@@ sim/tb_rgb_convolution_3x3_reflect.sv @@
// testbench for the rgb 3x3 convolution block: scoreboard against an in-bench predictor
module tb_rgb_convolution_3x3_reflect;
    import rgbc_pkg::*;

    localparam int MAXW = MAX_WIDTH_DEF;
    localparam int WATCHDOG_LIMIT = 20000;

    logic clk;
    logic rst_n;
    logic cfg_write;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_W-1:0] cfg_data;
    logic in_valid;
    logic in_ready;
    logic req_type;
    logic [7:0] in_red;
    logic [7:0] in_green;
    logic [7:0] in_blue;
    logic [7:0] in_alpha;
    logic out_valid;
    logic out_ready;
    logic [7:0] out_red;
    logic [7:0] out_green;
    logic [7:0] out_blue;
    logic [7:0] out_alpha;
    logic frame_end;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic [7:0] alpha;
        logic       last;
    } conv_pixel_t;

    conv_pixel_t pending_pixels[$];

    // predictor state
    logic [31:0] line_mem[2*MAXW];
    logic [31:0] win[3][3];
    int unsigned col_in;
    int unsigned row_in;
    int unsigned out_cnt;
    int unsigned fw;
    int unsigned fh;
    logic [23:0] krow[3];
    logic [10:0] width_reg;
    logic [12:0] height_reg;

    int errors;
    int idle_cycles;
    int items_sent;
    bit quiet_mode;
    bit rx_hold;

    rgb_convolution_3x3_reflect dut (
        .clk(clk), .rst_n(rst_n), .cfg_write(cfg_write), .cfg_index(cfg_index),
        .cfg_data(cfg_data), .in_valid(in_valid), .in_ready(in_ready),
        .req_type(req_type), .in_red(in_red), .in_green(in_green), .in_blue(in_blue),
        .in_alpha(in_alpha), .out_valid(out_valid), .out_ready(out_ready),
        .out_red(out_red), .out_green(out_green), .out_blue(out_blue),
        .out_alpha(out_alpha), .frame_end(frame_end)
    );

    initial clk = 1'b0;
    always #1 clk = ~clk;

    function automatic int unsigned clamp_dim(int unsigned v, int unsigned lo, int unsigned hi);
        if (v < lo)
            return lo;
        if (v > hi)
            return hi;
        return v;
    endfunction

    function automatic int signed kcoef(int r, int c);
        return int'($signed(krow[r][8*c +: 8]));
    endfunction

    function automatic conv_pixel_t filter_window(int lc, int cc, int rc, int tr, int br);
        conv_pixel_t res;
        int cols[3];
        int rows[3];
        int signed ksum;
        int signed acc;
        int signed q;
        logic [31:0] px;
        cols = '{lc, cc, rc};
        rows = '{tr, 1, br};
        ksum = 0;
        for (int r = 0; r < 3; r++)
            for (int c = 0; c < 3; c++)
                ksum += kcoef(r, c);
        if (ksum == 0)
            ksum = 1;
        res = '0;
        for (int ch = 0; ch < 3; ch++)
        begin
            acc = 0;
            for (int r = 0; r < 3; r++)
                for (int c = 0; c < 3; c++)
                begin
                    px = win[cols[c]][rows[r]];
                    acc += kcoef(2 - r, 2 - c) * int'({1'b0, px[8*ch +: 8]});
                end
            q = acc / ksum;
            if (q < 0)
                q = 0;
            if (q > 255)
                q = 255;
            case (ch)
                0: res.red = q[7:0];
                1: res.green = q[7:0];
                default: res.blue = q[7:0];
            endcase
        end
        px = win[cc][1];
        res.alpha = px[31:24];
        return res;
    endfunction

    task automatic predict_conv(input logic kind, input logic [31:0] px);
        int unsigned j;
        int unsigned a;
        int unsigned r;
        int unsigned c;
        logic [31:0] top;
        logic [31:0] mid;
        bit emit;
        conv_pixel_t res;
        if (kind == REQ_PIXEL && row_in == 0 && col_in == 0 && out_cnt == 0)
        begin
            fw = clamp_dim(width_reg, 2, MAXW);
            fh = clamp_dim(height_reg, 2, MAX_HEIGHT);
        end
        if (kind == REQ_FLUSH && row_in < fh)
            return;
        j = (col_in >= MAXW) ? MAXW - 1 : col_in;
        top = line_mem[j];
        mid = line_mem[MAXW + j];
        line_mem[j] = mid;
        line_mem[MAXW + j] = px;
        a = row_in * fw + j;
        emit = (a >= fw + 1) && (out_cnt < fw * fh);
        r = 0;
        c = 0;
        if (emit)
        begin
            if (j == 0)
            begin
                r = row_in - 2;
                c = fw - 1;
            end
            else
            begin
                r = row_in - 1;
                c = j - 1;
            end
        end
        if (emit && j == 0)
            res = filter_window(1, 2, 1, (r == 0) ? 2 : 0, (r == fh - 1) ? 0 : 2);
        for (int k = 0; k < 3; k++)
        begin
            win[0][k] = win[1][k];
            win[1][k] = win[2][k];
        end
        win[2][0] = top;
        win[2][1] = mid;
        win[2][2] = px;
        if (emit && j != 0)
            res = filter_window((c == 0) ? 2 : 0, 1, 2, (r == 0) ? 2 : 0,
                                (r == fh - 1) ? 0 : 2);
        col_in = j + 1;
        if (col_in >= fw)
        begin
            col_in = 0;
            row_in++;
        end
        if (!emit)
            return;
        out_cnt++;
        res.last = (out_cnt == fw * fh);
        if (out_cnt >= fw * fh)
        begin
            out_cnt = 0;
            col_in = 0;
            row_in = 0;
        end
        pending_pixels.push_back(res);
    endtask

    // leaves the write enable high, the caller drops it after the last write
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [23:0] value);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        @(posedge clk);
        case (idx)
            REG_KTOP: krow[0] = value;
            REG_KMID: krow[1] = value;
            REG_KBOT: krow[2] = value;
            REG_WIDTH: width_reg = value[10:0];
            default: height_reg = value[12:0];
        endcase
    endtask

    // called with the driver at a rising edge
    task automatic send_item(input logic kind, input logic [31:0] px);
        while (!quiet_mode && $urandom_range(99) < 24)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        req_type <= kind;
        in_red <= px[7:0];
        in_green <= px[15:8];
        in_blue <= px[23:16];
        in_alpha <= px[31:24];
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        predict_conv(kind, px);
        items_sent++;
    endtask

    task automatic wait_drain();
        in_valid <= 1'b0;
        while (pending_pixels.size() != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);
    endtask

    task automatic configure(input logic [23:0] k0, input logic [23:0] k1,
                             input logic [23:0] k2, input int w, input int h);
        wait_drain();
        write_reg(REG_KTOP, k0);
        write_reg(REG_KMID, k1);
        write_reg(REG_KBOT, k2);
        write_reg(REG_WIDTH, 24'(w));
        write_reg(REG_HEIGHT, 24'(h));
        cfg_write <= 1'b0;
    endtask

    function automatic logic [31:0] rand_px();
        return $urandom;
    endfunction

    function automatic int unsigned fw_next();
        return clamp_dim(width_reg, 2, MAXW);
    endfunction

    function automatic int unsigned fh_next();
        return clamp_dim(height_reg, 2, MAX_HEIGHT);
    endfunction

    // one whole frame, then a mix of flushes and pixels until the frame's last result is predicted
    task automatic run_frame(input int mode);
        int unsigned n;
        n = fw_next() * fh_next();
        for (int i = 0; i < n; i++)
        begin
            if (mode == 1 && $urandom_range(9) == 0)
                send_item(REQ_FLUSH, rand_px());
            case (mode)
                2: send_item(REQ_PIXEL, (i % 2) ? 32'hFFFFFFFF : 32'h00000000);
                default: send_item(REQ_PIXEL, rand_px());
            endcase
        end
        while (row_in != 0 || col_in != 0 || out_cnt != 0)
            send_item(($urandom_range(3) == 0) ? REQ_PIXEL : REQ_FLUSH, rand_px());
    endtask

    task automatic test_box_blur_extremes();
        configure(KROW_RESET, KROW_RESET, KROW_RESET, 2, 2);
        send_item(REQ_FLUSH, 32'h0);
        run_frame(2);
        configure(24'h010101, 24'h010101, 24'h010101, 3, 3);
        run_frame(0);
    endtask

    task automatic test_kernel_signs();
        configure(24'hFF00FF, 24'h000800, 24'h7F8001, 4, 3);
        run_frame(0);
        configure(24'h000000, 24'h000000, 24'h000000, 3, 2);
        run_frame(0);
        configure(24'hFFFFFF, 24'hFF08FF, 24'hFFFFFF, 2, 4);
        run_frame(2);
        configure(24'h808080, 24'h7F7F7F, 24'h808080, 3, 3);
        run_frame(0);
    endtask

    task automatic test_size_clamp();
        // out of range sizes clamp to the minimum
        configure(KROW_RESET, 24'h010201, KROW_RESET, 0, 1);
        run_frame(0);
    endtask

    task automatic test_random_frames();
        while (items_sent < 1900)
        begin
            configure(24'($urandom), 24'($urandom), 24'($urandom), $urandom_range(2, 12),
                      $urandom_range(2, 9));
            if ($urandom_range(3) == 0)
                configure({3{$urandom_range(0, 3) == 0 ? 8'h01 : 8'(($urandom_range(0,6)) - 3)}},
                          {8'($urandom_range(0, 6) - 3), 8'h04, 8'($urandom_range(0, 6) - 3)},
                          {3{8'($urandom_range(0, 2))}}, $urandom_range(2, 7),
                          $urandom_range(2, 6));
            quiet_mode = (items_sent > 800 && items_sent < 1100);
            run_frame(1);
        end
        quiet_mode = 1'b0;
    endtask

    task automatic test_backpressure();
        configure(KROW_RESET, KROW_RESET, KROW_RESET, 8, 6);
        rx_hold = 1'b1;
        run_frame(0);
        // sender waits until everything has come out
        wait_drain();
        configure(24'h02FF01, 24'h03FE05, 24'h0101FF, 4096 % 2048, 2);
        run_frame(0);
        configure(KROW_RESET, KROW_RESET, KROW_RESET, 640, 480);
        wait_drain();
    endtask

    // receiver: random idling, and one long hold-off so the block backs up onto the input
    initial
    begin
        int hold_count;
        out_ready = 1'b0;
        hold_count = 0;
        wait (rst_n);
        forever
        begin
            @(posedge clk);
            if (rx_hold && hold_count < 300)
            begin
                hold_count++;
                out_ready <= 1'b0;
            end
            else
                out_ready <= quiet_mode ? 1'b1 : ($urandom_range(99) >= 24);
        end
    end

    // result checker
    always @(posedge clk)
    begin
        conv_pixel_t exp_px;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_pixels.size() == 0)
            begin
                $error("unexpected transaction out_red=%0d", out_red);
                errors++;
            end
            else
            begin
                exp_px = pending_pixels.pop_front();
                if (out_red !== exp_px.red)
                begin
                    $error("out_red expected %0d actual %0d", exp_px.red, out_red);
                    errors++;
                end
                if (out_green !== exp_px.green)
                begin
                    $error("out_green expected %0d actual %0d", exp_px.green, out_green);
                    errors++;
                end
                if (out_blue !== exp_px.blue)
                begin
                    $error("out_blue expected %0d actual %0d", exp_px.blue, out_blue);
                    errors++;
                end
                if (out_alpha !== exp_px.alpha)
                begin
                    $error("out_alpha expected %0d actual %0d", exp_px.alpha, out_alpha);
                    errors++;
                end
                if (frame_end !== exp_px.last)
                begin
                    $error("frame_end expected %0d actual %0d", exp_px.last, frame_end);
                    errors++;
                end
            end
        end
    end

    // watchdog on cycles with no transaction
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || cfg_write || !rst_n)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("FAIL rgb_convolution_3x3_reflect");
            $finish;
        end
    end

    initial
    begin
        rst_n = 1'b0;
        cfg_write = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        in_valid = 1'b0;
        req_type = REQ_PIXEL;
        in_red = '0;
        in_green = '0;
        in_blue = '0;
        in_alpha = '0;
        errors = 0;
        idle_cycles = 0;
        items_sent = 0;
        quiet_mode = 1'b0;
        rx_hold = 1'b0;
        krow = '{KROW_RESET, KROW_RESET, KROW_RESET};
        width_reg = IW_RESET;
        height_reg = IH_RESET;
        col_in = 0;
        row_in = 0;
        out_cnt = 0;
        fw = 640;
        fh = 480;
        for (int i = 0; i < 2 * MAXW; i++)
            line_mem[i] = '0;
        for (int a = 0; a < 3; a++)
            for (int b = 0; b < 3; b++)
                win[a][b] = '0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_box_blur_extremes();
        test_kernel_signs();
        test_size_clamp();
        test_backpressure();
        test_random_frames();
        wait_drain();
        if (errors == 0)
            $display("PASS rgb_convolution_3x3_reflect");
        else
            $display("FAIL rgb_convolution_3x3_reflect");
        $finish;
    end

endmodule
